// ===== rtl/acfilt_pkg.sv =====
// Package: shared types, constants and hex decode for the ASCII CAN frame filter.
`timescale 1ns / 1ps

package acfilt_pkg;

  // Frame format constants
  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam logic [7:0]  START_CHAR     = 8'h74;       // 't'
  localparam logic [23:0] ID_RESET       = 24'h304631;  // "0F1"
  localparam logic [3:0]  LEN_MASK       = 4'hF;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID1,
    PH_ID2,
    PH_ID3,
    PH_LEN,
    PH_DATA
  } phase_e;

  // One result item
  typedef struct packed {
    logic [7:0] first_data_byte;
    logic [3:0] data_byte_count;
  } result_t;

  // Hex digit decode: bit 4 set when the character is a valid digit
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n.ok    = 1'b1;
    n.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

  // Pair decode: bad high digit gives 0, bad low digit keeps the high digit alone
  function automatic logic [7:0] decode_pair(input logic [7:0] hi_c, input logic [7:0] lo_c);
    nibble_t    hi;
    nibble_t    lo;
    logic [7:0] v;
    hi = hex_nibble(hi_c);
    lo = hex_nibble(lo_c);
    if (!hi.ok) begin
      v = 8'd0;
    end else if (!lo.ok) begin
      v = {4'd0, hi.value};
    end else begin
      v = {hi.value, lo.value};
    end
    return v;
  endfunction

  // Length nibble clamped to 1..MAX_DATA_BYTES
  function automatic logic [3:0] clamp_len(input logic [7:0] c);
    logic [3:0] n;
    n = c[3:0] & LEN_MASK;
    if (n == 4'd0) begin
      n = 4'd1;
    end else if (n > 4'(MAX_DATA_BYTES)) begin
      n = 4'(MAX_DATA_BYTES);
    end
    return n;
  endfunction

endpackage

// ===== rtl/ascii_can_frame_filter_top.sv =====
// Top level of the ASCII CAN frame filter.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_ready_o, received_char_i) carries one ASCII
//   character per transfer. Output channel (out_valid_o / out_ready_i) carries
//   one result per matching frame: first_data_byte_o and data_byte_count_o.
//   cfg_we_i writes cfg_wdata_i (three ID characters, first in the high byte)
//   into the match register; write it only while no frame is in progress.
// Timing:
//   A character is captured in an input register and parsed from there;
//   a result is written into the output buffer register before it is
//   presented on the output.
//   One character is taken every cycle while the result buffer is not full.
// Stall:
//   Results queue in a two-entry buffer. When it is full the parser holds its
//   input register and in_ready_o drops until the receiver takes a result.
// Reset:
//   rst_ni clears the parser to idle, empties the buffer and loads the match
//   register with "0F1".
module ascii_can_frame_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  received_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  first_data_byte_o,
  output logic [3:0]  data_byte_count_o,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i
);

  logic        in_vld_q;
  logic [7:0]  in_char_q;
  logic [23:0] match_id_q;
  logic        buf_full;
  logic        parse_go;
  logic        res_vld;
  acfilt_pkg::result_t res;
  acfilt_pkg::result_t out_data;

  // Parser consumes its input when the buffer has room
  assign parse_go   = in_vld_q && !buf_full;
  assign in_ready_o = !in_vld_q || !buf_full;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= received_char_i;
    end
  end

  // Match register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q <= acfilt_pkg::ID_RESET;
    end else if (cfg_we_i) begin
      match_id_q <= cfg_wdata_i;
    end
  end

  acfilt_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_vld_i (parse_go),
    .char_i     (in_char_q),
    .match_id_i (match_id_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  acfilt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (res_vld),
    .wr_data_i   (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign first_data_byte_o = out_data.first_data_byte;
  assign data_byte_count_o = out_data.data_byte_count;

endmodule

// ===== rtl/acfilt_parser.sv =====
// Frame parser: state machine that consumes one registered character per cycle while char_vld_i is high.
`timescale 1ns / 1ps

module acfilt_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 char_vld_i,
  input  logic [7:0]           char_i,
  input  logic [23:0]          match_id_i,
  output logic                 res_vld_o,
  output acfilt_pkg::result_t  res_o
);

  acfilt_pkg::phase_e phase_q, phase_d;
  logic [23:0] id_seen_q, id_seen_d;
  logic [3:0]  exp_bytes_q, exp_bytes_d;
  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  hi_char_q, hi_char_d;
  logic        second_due_q, second_due_d;
  logic [7:0]  first_q, first_d;

  logic [7:0]  pair_val;
  logic [7:0]  first_now;
  logic        last_pair;

  assign pair_val  = acfilt_pkg::decode_pair(hi_char_q, char_i);
  assign first_now = (byte_pos_q == 3'd0) ? pair_val : first_q;
  assign last_pair = ({1'b0, byte_pos_q} + 4'd1) >= exp_bytes_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= acfilt_pkg::PH_IDLE;
      id_seen_q    <= 24'd0;
      exp_bytes_q  <= 4'd0;
      byte_pos_q   <= 3'd0;
      hi_char_q    <= 8'd0;
      second_due_q <= 1'b0;
      first_q      <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      id_seen_q    <= id_seen_d;
      exp_bytes_q  <= exp_bytes_d;
      byte_pos_q   <= byte_pos_d;
      hi_char_q    <= hi_char_d;
      second_due_q <= second_due_d;
      first_q      <= first_d;
    end
  end

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    id_seen_d    = id_seen_q;
    exp_bytes_d  = exp_bytes_q;
    byte_pos_d   = byte_pos_q;
    hi_char_d    = hi_char_q;
    second_due_d = second_due_q;
    first_d      = first_q;
    res_vld_o    = 1'b0;
    res_o.first_data_byte = first_now;
    res_o.data_byte_count = exp_bytes_q;
    if (char_vld_i) begin
      case (phase_q)
        acfilt_pkg::PH_ID1: begin
          id_seen_d = {id_seen_q[15:0], char_i};
          phase_d   = acfilt_pkg::PH_ID2;
        end
        acfilt_pkg::PH_ID2: begin
          id_seen_d = {id_seen_q[15:0], char_i};
          phase_d   = acfilt_pkg::PH_ID3;
        end
        acfilt_pkg::PH_ID3: begin
          id_seen_d = {id_seen_q[15:0], char_i};
          phase_d   = ({id_seen_q[15:0], char_i} == match_id_i) ?
                      acfilt_pkg::PH_LEN : acfilt_pkg::PH_IDLE;
        end
        acfilt_pkg::PH_LEN: begin
          exp_bytes_d  = acfilt_pkg::clamp_len(char_i);
          byte_pos_d   = 3'd0;
          second_due_d = 1'b0;
          first_d      = 8'd0;
          phase_d      = acfilt_pkg::PH_DATA;
        end
        acfilt_pkg::PH_DATA: begin
          if (!second_due_q) begin
            hi_char_d    = char_i;
            second_due_d = 1'b1;
          end else begin
            second_due_d = 1'b0;
            first_d      = first_now;
            if (last_pair) begin
              res_vld_o  = 1'b1;
              phase_d    = acfilt_pkg::PH_IDLE;
              byte_pos_d = 3'd0;
            end else begin
              byte_pos_d = byte_pos_q + 3'd1;
            end
          end
        end
        default: begin
          // Idle: look for frame start
          phase_d = acfilt_pkg::PH_IDLE;
          if (char_i == acfilt_pkg::START_CHAR) begin
            id_seen_d = 24'd0;
            phase_d   = acfilt_pkg::PH_ID1;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/acfilt_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the output receiver.
`timescale 1ns / 1ps

module acfilt_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  acfilt_pkg::result_t  wr_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output acfilt_pkg::result_t  out_data_o
);

  acfilt_pkg::result_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       rd_en;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign rd_en       = out_valid_o && out_ready_i;

  // Entry count
  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en) begin
      count_d = count_q + 2'd1;
    end else if (!wr_en_i && rd_en) begin
      count_d = count_q - 2'd1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
